// ===== rtl/per_place_interval_conflict_check_top_assert.svh =====
// Assertion macros for the per-place interval conflict check.
// Included by the checker module; needs no other file.
`ifndef PER_PLACE_INTERVAL_CONFLICT_CHECK_TOP_ASSERT_SVH
`define PER_PLACE_INTERVAL_CONFLICT_CHECK_TOP_ASSERT_SVH

// Check a condition on the same edge as its trigger.
`define PPICC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition on the edge after its trigger.
`define PPICC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ppicc_pkg.sv =====
// Shared types and constants for the per-place interval conflict check.
// No dependencies; used by the cell and the top level.
`timescale 1ns / 1ps

package ppicc_pkg;

   localparam int PLACE_W         = 16;
   localparam int START_W         = 32;
   localparam int DUR_W           = 16;
   localparam int END_W           = 33;
   localparam int TDATA_IN_W      = 64;
   localparam int TDATA_OUT_W     = 8;
   localparam int MAX_ENTRIES_DEF = 64;

   // One stored interval
   typedef struct packed {
      logic [PLACE_W-1:0] place;
      logic [START_W-1:0] start_sec;
      logic [END_W-1:0]   stop_sec;
   } entry_type;

   // What a cell holds and hands to its neighbor
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } cell_state_type;

   // Broadcast controls for every cell
   typedef struct packed {
      logic cmp;
      logic shift;
      logic clear;
   } cell_ctl_type;

endpackage

// ===== rtl/ppicc_cell.sv =====
// One cell of the interval chain: holds one entry, checks it against the
// broadcast new entry and passes its entry and conflict flag down the chain.
`timescale 1ns / 1ps

module ppicc_cell
   import ppicc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cell_ctl_type   ctl,
   input  entry_type      new_entry,
   input  cell_state_type prev_state,
   input  logic           prev_flag,
   output cell_state_type cur_state,
   output logic           cur_flag
);

   logic          valid_ff;
   logic          valid_in;
   entry_type     entry_ff;
   logic          flag_ff;
   logic          flag_in;
   logic          same_place;
   logic          new_in_old;
   logic          old_in_new;
   logic          hit;
   logic [END_W-1:0] old_start;
   logic [END_W-1:0] new_start;

   // Compare the stored entry with the new one
   always_comb begin
      old_start  = {1'b0, entry_ff.start_sec};
      new_start  = {1'b0, new_entry.start_sec};
      same_place = (entry_ff.place == new_entry.place);
      new_in_old = (new_start >= old_start) && (new_start < entry_ff.stop_sec);
      old_in_new = (old_start >= new_start) && (old_start < new_entry.stop_sec);
      hit        = ctl.cmp && valid_ff && same_place && (new_in_old || old_in_new);
   end

   // Next valid bit: clear on set close, take the neighbor's on a shift
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.shift) begin
         valid_in = prev_state.valid;
      end
      flag_in = prev_flag | hit;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         flag_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         flag_ff  <= flag_in;
      end
   end

   // Payload: advance on a shift
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         entry_ff <= prev_state.entry;
      end
   end

   assign cur_state.valid = valid_ff;
   assign cur_state.entry = entry_ff;
   assign cur_flag        = flag_ff;

endmodule

// ===== rtl/per_place_interval_conflict_check_top.sv =====
// Top level of the per-place interval conflict check: a chain of cells plus
// the set-close drain and the result register. Uses ppicc_pkg and ppicc_cell.
//
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata: place, start_sec, duration_min; tlast
// rsp      out  rsp_tvalid/rsp_tready  tdata: schedule_ok, table_overflow
//
// Entries that do not close a set stream back to back while no drain runs.
// A closing beat starts a drain while conflict flags ripple down the cell chain;
// req_tready is low for the whole drain.
// The drain ends, the result is registered and req_tready rises again once the
// previous result beat has left; a result waiting on rsp_tready alone keeps req open.
// Reset is synchronous and empties the table; no clearing pass is needed.
`timescale 1ns / 1ps

module per_place_interval_conflict_check_top
   import ppicc_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [TDATA_IN_W-1:0]  req_tdata,  // [15:0] place, [47:16] start_sec,
                                              // [63:48] duration_min
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [TDATA_OUT_W-1:0] rsp_tdata   // [0] schedule_ok, [1] table_overflow,
                                              // [7:2] zero
);

   localparam int CNT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_ENTRIES - 1);

   logic                 req_fire;
   logic                 full;
   logic                 done;
   logic                 tail_flag;
   logic [DUR_W-1:0]     dur;
   entry_type            new_entry;
   cell_ctl_type         ctl;
   cell_state_type       chain_state [MAX_ENTRIES];
   logic                 chain_flag  [MAX_ENTRIES];

   logic                 drain_ff, drain_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 conflict_ff, conflict_in;
   logic                 overflow_ff, overflow_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic                 rsp_ov_ff, rsp_ov_in;

   // Unpack the beat and form end = start + 60 * duration
   always_comb begin
      dur                 = req_tdata[63:48];
      new_entry.place     = req_tdata[15:0];
      new_entry.start_sec = req_tdata[47:16];
      new_entry.stop_sec  = {1'b0, new_entry.start_sec}
                          + END_W'({dur, 6'b0}) - END_W'({dur, 2'b0});
   end

   assign req_tready = ~drain_ff;
   assign req_fire   = req_tvalid & req_tready;
   assign full       = chain_state[MAX_ENTRIES-1].valid;
   assign tail_flag  = chain_flag[MAX_ENTRIES-1];

   // Broadcast controls: store and compare only while room is left; clear on a closing beat
   always_comb begin
      ctl.cmp   = req_fire & ~full;
      ctl.shift = req_fire & ~full;
      ctl.clear = req_fire & req_tlast;
   end

   // Chain of cells; the first takes the new entry
   genvar gi;
   generate
      for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
         cell_state_type up_state;
         logic           up_flag;
         if (gi == 0) begin : g_head
            assign up_state.valid = 1'b1;
            assign up_state.entry = new_entry;
            assign up_flag        = 1'b0;
         end else begin : g_body
            assign up_state = chain_state[gi-1];
            assign up_flag  = chain_flag[gi-1];
         end
         ppicc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .new_entry  (new_entry),
            .prev_state (up_state),
            .prev_flag  (up_flag),
            .cur_state  (chain_state[gi]),
            .cur_flag   (chain_flag[gi])
         );
      end
   endgenerate

   // Drain, sticky flags and result register
   always_comb begin
      done         = drain_ff && (cnt_ff == CNT_LAST) && (~rsp_valid_ff || rsp_tready);
      drain_in     = drain_ff;
      cnt_in       = cnt_ff;
      conflict_in  = conflict_ff | tail_flag;
      overflow_in  = overflow_ff | (req_fire & full);
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_ov_in    = rsp_ov_ff;
      if (req_fire && req_tlast) begin
         drain_in = 1'b1;
         cnt_in   = '0;
      end else if (done) begin
         drain_in     = 1'b0;
         conflict_in  = 1'b0;
         overflow_in  = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_ok_in    = ~(conflict_ff | tail_flag);
         rsp_ov_in    = overflow_ff;
      end else if (drain_ff && (cnt_ff != CNT_LAST)) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff     <= 1'b0;
         cnt_ff       <= '0;
         conflict_ff  <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         drain_ff     <= drain_in;
         cnt_ff       <= cnt_in;
         conflict_ff  <= conflict_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      rsp_ok_ff <= rsp_ok_in;
      rsp_ov_ff <= rsp_ov_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(TDATA_OUT_W-2){1'b0}}, rsp_ov_ff, rsp_ok_ff};

endmodule

// ===== rtl/ppicc_checker.sv =====
// Port-level checker for the per-place interval conflict check, bound to
// the top level. Uses ppicc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "per_place_interval_conflict_check_top_assert.svh"

module ppicc_checker
   import ppicc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [TDATA_IN_W-1:0]  req_tdata,  // [15:0] place, [47:16] start_sec,
                                             // [63:48] duration_min
   input logic                   req_tlast,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [TDATA_OUT_W-1:0] rsp_tdata   // [0] schedule_ok, [1] table_overflow
);

   logic last_beat;
   logic fresh_rsp;
   logic rsp_seen_ff;

   // Remember whether a result was offered in the previous cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_seen_ff <= 1'b0;
      end else begin
         rsp_seen_ff <= rsp_tvalid;
      end
   end

   assign last_beat = req_tvalid && req_tready && req_tlast;
   assign fresh_rsp = rsp_tvalid && !rsp_seen_ff;

   // Result stays offered until taken
   `PPICC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp beat dropped while stalled")
   // A closing beat starts the drain
   `PPICC_ASSERT_NEXT(a_drain_start, clock, reset, last_beat, !req_tready, "req taken right after a closing beat")
   // A new result only comes out of a drain
   `PPICC_ASSERT_NOW(a_rsp_from_drain, clock, reset, fresh_rsp, !$past(req_tready), "result without a drain")
   // Padding bits of the result stay zero
   `PPICC_ASSERT_NOW(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[7:2] == 6'd0, "nonzero result padding")

endmodule

bind per_place_interval_conflict_check_top ppicc_checker u_checker (.*);

// ===== dv/tb.sv =====
// Testbench for per_place_interval_conflict_check_top: streams booked-interval sets and
// checks each verdict beat against an in-bench predictor of the conflict table.
// Depends on ppicc_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb;
   import ppicc_pkg::*;

   localparam int TABLE_DEPTH   = MAX_ENTRIES_DEF;
   localparam int SET_MAX       = 96;
   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = TABLE_DEPTH + 40;

   typedef enum int {STYLE_SPARSE, STYLE_CROWDED, STYLE_CHAINED} set_style_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [TDATA_IN_W-1:0]  req_tdata  = '0;  // [15:0] place, [47:16] start_sec,
                                             // [63:48] duration_min
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [TDATA_OUT_W-1:0] rsp_tdata;        // [0] schedule_ok, [1] table_overflow,
                                             // [7:2] zero

   // Predicted booking table and set flags
   logic [PLACE_W-1:0]     booked_place [TABLE_DEPTH];
   logic [START_W-1:0]     booked_start [TABLE_DEPTH];
   logic [END_W-1:0]       booked_stop  [TABLE_DEPTH];
   int                     booked_count = 0;
   bit                     clash_seen   = 1'b0;
   bit                     full_seen    = 1'b0;
   logic [TDATA_OUT_W-1:0] pending_verdicts [$];

   int idle_pct     = 0;
   int stall_pct    = 0;
   bit hold_on      = 1'b0;
   int hold_count   = 0;
   int quiet_cycles = 0;
   int fail_count   = 0;

   always #2 clock = ~clock;

   per_place_interval_conflict_check_top #(
      .MAX_ENTRIES (TABLE_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Book one accepted interval; on the closing beat queue the verdict and clear the set
   function automatic void book_interval(input logic [PLACE_W-1:0] place,
                                         input logic [START_W-1:0] start,
                                         input logic [DUR_W-1:0]   dur,
                                         input logic               last);
      logic [END_W-1:0] stop;
      logic [END_W-1:0] from;
      stop = END_W'(start) + END_W'(dur) * END_W'(60);
      from = END_W'(start);
      if (booked_count < TABLE_DEPTH) begin
         for (int i = 0; i < booked_count; i++) begin
            if (booked_place[i] == place &&
                ((from >= END_W'(booked_start[i]) && from < booked_stop[i]) ||
                 (END_W'(booked_start[i]) >= from && END_W'(booked_start[i]) < stop)))
               clash_seen = 1'b1;
         end
         booked_place[booked_count] = place;
         booked_start[booked_count] = start;
         booked_stop[booked_count]  = stop;
         booked_count++;
      end else begin
         full_seen = 1'b1;
      end
      if (last) begin
         pending_verdicts.insert(pending_verdicts.size(), {6'b0, full_seen, !clash_seen});
         booked_count = 0;
         clash_seen   = 1'b0;
         full_seen    = 1'b0;
      end
   endfunction

   // Offer one beat, after random idle cycles, and book it once accepted
   task automatic send_entry(input logic [PLACE_W-1:0] place,
                             input logic [START_W-1:0] start,
                             input logic [DUR_W-1:0]   dur,
                             input logic               last);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {dur, start, place};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book_interval(place, start, dur, last);
   endtask

   // Build one set of the given style and size, then send it in forward or reverse order
   task automatic send_set(input set_style_type style, input int size);
      logic [PLACE_W-1:0] places [SET_MAX];
      logic [START_W-1:0] starts [SET_MAX];
      logic [DUR_W-1:0]   durs   [SET_MAX];
      logic [PLACE_W-1:0] base_place;
      logic [START_W-1:0] base_start;
      logic [END_W-1:0]   cursor;
      bit                 reverse;
      int                 idx;
      base_place = PLACE_W'($urandom);
      base_start = $urandom;
      cursor     = END_W'(base_start);
      for (int i = 0; i < size; i++) begin
         case (style)
            STYLE_SPARSE: begin
               places[i] = PLACE_W'($urandom);
               starts[i] = $urandom;
               durs[i]   = DUR_W'($urandom);
            end
            STYLE_CROWDED: begin
               places[i] = base_place + PLACE_W'($urandom_range(0, 1));
               starts[i] = base_start + $urandom_range(0, 3600);
               durs[i]   = DUR_W'($urandom_range(0, 10));
            end
            default: begin
               // back-to-back intervals on one place, some touching, some with gaps
               places[i] = base_place;
               starts[i] = cursor[START_W-1:0];
               durs[i]   = DUR_W'($urandom_range(0, 30));
               cursor    = cursor + END_W'(durs[i]) * END_W'(60);
               if ($urandom_range(0, 1))
                  cursor = cursor + END_W'($urandom_range(1, 600));
            end
         endcase
      end
      reverse = 1'($urandom_range(0, 1));
      for (int i = 0; i < size; i++) begin
         idx = reverse ? size - 1 - i : i;
         send_entry(places[idx], starts[idx], durs[idx], i == size - 1);
      end
   endtask

   // Same-place overlap in both directions, touching ends, other place
   task automatic test_overlap_rules();
      idle_pct  = 0;
      stall_pct = 0;
      send_entry(16'd1, 32'd1000, 16'd2, 1'b0);
      send_entry(16'd1, 32'd1119, 16'd1, 1'b1);
      send_entry(16'd1, 32'd1000, 16'd2, 1'b0);
      send_entry(16'd1, 32'd1120, 16'd1, 1'b1);
      send_entry(16'd1, 32'd1000, 16'd2, 1'b0);
      send_entry(16'd2, 32'd1000, 16'd2, 1'b1);
      send_entry(16'd1, 32'd2000, 16'd1, 1'b0);
      send_entry(16'd1, 32'd1990, 16'd1, 1'b1);
   endtask

   // Zero-length intervals against equal starts, interior points and end points
   task automatic test_zero_length();
      send_entry(16'd3, 32'd500, 16'd0, 1'b0);
      send_entry(16'd3, 32'd500, 16'd5, 1'b1);
      send_entry(16'd3, 32'd500, 16'd0, 1'b0);
      send_entry(16'd3, 32'd500, 16'd0, 1'b1);
      send_entry(16'd3, 32'd400, 16'd5, 1'b0);
      send_entry(16'd3, 32'd700, 16'd0, 1'b1);
      send_entry(16'd3, 32'd400, 16'd5, 1'b0);
      send_entry(16'd3, 32'd699, 16'd0, 1'b1);
   endtask

   // Field extremes, including an end past 32 bits
   task automatic test_field_extremes();
      send_entry(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      send_entry(16'h0000, 32'h0000_0000, 16'h0000, 1'b0);
      send_entry(16'h0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      send_entry(16'hFFFF, 32'hFFFF_FFF0, 16'hFFFF, 1'b0);
      send_entry(16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 1'b1);
   endtask

   // Exactly full table, one extra closing beat that would clash, longer overfilled sets
   task automatic test_table_full();
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_entry(16'd7, START_W'(i * 100), 16'd1, i == TABLE_DEPTH - 1);
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_entry(16'd7, START_W'(i * 100), 16'd1, 1'b0);
      send_entry(16'd7, 32'd0, 16'd1, 1'b1);
      send_set(STYLE_CROWDED, TABLE_DEPTH + 2);
      send_set(STYLE_CHAINED, TABLE_DEPTH + 6);
   endtask

   // Random sets under one idling mix
   task automatic run_random_phase(input int idle, input int stall, input int items);
      int            sent;
      int            size;
      set_style_type style;
      idle_pct  = idle;
      stall_pct = stall;
      sent      = 0;
      while (sent < items) begin
         size = ($urandom_range(0, 29) == 0) ? $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 8)
                                             : $urandom_range(1, 12);
         case ($urandom_range(0, 9))
            0, 1:       style = STYLE_SPARSE;
            2, 3, 4, 5: style = STYLE_CROWDED;
            default:    style = STYLE_CHAINED;
         endcase
         send_set(style, size);
         sent += size;
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0, 250);
      run_random_phase(47, 0, 250);
      run_random_phase(0, 47, 250);
      run_random_phase(10, 10, 250);
   endtask

   // Hold the result side off while sets keep coming, so the input stalls
   task automatic test_result_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      req_tvalid <= 1'b0;
      @(negedge clock);
      hold_on = 1'b1;
      @(posedge clock);
      repeat (6) send_set(STYLE_CROWDED, $urandom_range(2, 8));
   endtask

   // Drive the result ready: long hold when asked, random stalls otherwise
   always @(posedge clock) begin
      if (hold_on) begin
         rsp_tready <= 1'b0;
         hold_count = hold_count + 1;
         if (hold_count >= HOLD_CYCLES) begin
            hold_on    = 1'b0;
            hold_count = 0;
         end
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic note_failure(input string what, input logic [TDATA_OUT_W-1:0] want,
                               input logic [TDATA_OUT_W-1:0] got);
      if (fail_count < 10)
         $display("%0t: %s: expected %b, got %b", $time, what, want, got);
      fail_count++;
   endtask

   // Check each verdict beat against the oldest queued verdict
   always @(posedge clock) begin
      logic [TDATA_OUT_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            note_failure("verdict with no closed set", '0, rsp_tdata);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tdata[0] !== want[0])
               note_failure("schedule_ok", want, rsp_tdata);
            if (rsp_tdata[1] !== want[1])
               note_failure("table_overflow", want, rsp_tdata);
            if (rsp_tdata[7:2] !== 6'b0)
               note_failure("padding bits", want, rsp_tdata);
         end
      end
   end

   // Watchdog: end the run after too long without any beat
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_overlap_rules();
      test_zero_length();
      test_field_extremes();
      test_table_full();
      test_random_traffic();
      test_result_backpressure();
      req_tvalid <= 1'b0;
      // wait out outstanding verdicts, then watch for strays
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_verdicts.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
